[rtl/afd_pkg.sv]
// Package for the audio frame deframer: payload structs, status and register codes,
// and the fixed frame constants.
// It has no dependencies.
package afd_pkg;

    // Fixed frame layout and limits.
    localparam int HEADER_BYTES      = 16;
    localparam int MAX_FRAME_SAMPLES = 256;
    localparam int POS_W             = 10;

    // Depth of the result queue (a power of two).
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // End-of-frame status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_BAD_HDR = 2'd2,
        ST_LEN     = 2'd3
    } t_status;

    // Configuration register indexes (byte address = 4 * index).
    typedef enum logic [1:0] {
        REG_VERSION  = 2'd0,
        REG_CHANNELS = 2'd1,
        REG_BITS     = 2'd2,
        REG_MAX_SMP  = 2'd3
    } t_reg_idx;

    // One input transfer.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // One result transfer.
    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        t_status            status;
        logic [15:0]        frame_version;
        logic [15:0]        rate_hz;
        logic [15:0]        channel_count;
        logic [15:0]        sample_bits;
        logic [15:0]        sample_total;
        logic [15:0]        sequence_number;
        logic [31:0]        stamp_ms;
        logic               end_of_frame;
    } t_out;

endpackage

[rtl/audio_frame_deframer.sv]
// Audio frame deframer top level: header parsing, sample assembly, result queue
// and the APB-style configuration registers.
// It depends on afd_pkg.

// The block takes one byte per cycle and can accept a byte in every cycle. The
// 16-byte little-endian header is captured byte by byte and checked against the
// configuration registers at its last byte; after a valid header each pair of
// bytes up to the sample count yields a signed 16-bit sample result, and the last
// byte yields a status result with the header fields. All per-byte work is done in
// the cycle the byte is transferred and the results are written into a four-entry
// result queue. A last byte that also completes a sample produces two results, and
// the input stalls while fewer than two queue entries are free, so the input rate
// follows the output rate once the queue fills. Configuration registers sit at
// byte addresses 0, 4, 8 and 12 and should be written only while no frame is open.
module audio_frame_deframer
    import afd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [15:0] r_exp_version;
    logic [15:0] r_exp_channels;
    logic [15:0] r_exp_bits;
    logic [8:0]  r_max_samples;

    // Frame state.
    logic [POS_W-1:0] r_byte_pos,  n_byte_pos;
    logic [15:0]      r_hdr_version, n_hdr_version;
    logic [15:0]      r_hdr_rate,    n_hdr_rate;
    logic [15:0]      r_hdr_channels, n_hdr_channels;
    logic [15:0]      r_hdr_bits,    n_hdr_bits;
    logic [15:0]      r_hdr_count,   n_hdr_count;
    logic [15:0]      r_hdr_seq,     n_hdr_seq;
    logic [31:0]      r_hdr_ts,      n_hdr_ts;
    logic [7:0]       r_low_byte,    n_low_byte;
    logic             r_hdr_valid,   n_hdr_valid;

    // Result queue.
    t_out               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]   r_count,  n_count;

    logic             in_xfer;
    logic             out_xfer;
    logic             is_header;
    logic [POS_W-1:0] pay_off;
    logic [POS_W-1:0] total;
    logic             hdr_ok;
    logic             has_sample;
    logic             has_status;
    logic [1:0]       push_cnt;
    t_out             sample_res;
    t_out             status_res;
    t_out             res_a;
    logic             cfg_wr;

    // Replace one byte of a 16-bit header word.
    function automatic logic [15:0] put_byte16(input logic [15:0] word,
                                               input logic hi, input logic [7:0] b);
        logic [15:0] res;
        res = word;
        if (hi) begin
            res[15:8] = b;
        end else begin
            res[7:0] = b;
        end
        return res;
    endfunction

    // Handshakes: stall input while fewer than two queue entries are free.
    assign o_stall  = (r_count > (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_count != '0);
    assign out_xfer = o_valid && !i_stall;
    assign o_data   = r_fifo[r_rd_ptr];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version  <= 16'd1;
            r_exp_channels <= 16'd1;
            r_exp_bits     <= 16'd16;
            r_max_samples  <= 9'd160;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_VERSION:  r_exp_version  <= pwdata[15:0];
                REG_CHANNELS: r_exp_channels <= pwdata[15:0];
                REG_BITS:     r_exp_bits     <= pwdata[15:0];
                REG_MAX_SMP:  r_max_samples  <= pwdata[8:0];
                default:      r_max_samples  <= r_max_samples;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_VERSION:  prdata = {16'd0, r_exp_version};
            REG_CHANNELS: prdata = {16'd0, r_exp_channels};
            REG_BITS:     prdata = {16'd0, r_exp_bits};
            REG_MAX_SMP:  prdata = {23'd0, r_max_samples};
            default:      prdata = '0;
        endcase
    end

    // Header check against the registers; all checked words are complete by byte 15.
    assign hdr_ok = (r_hdr_version == r_exp_version)
                 && (r_hdr_channels == r_exp_channels)
                 && (r_hdr_bits == r_exp_bits)
                 && (r_hdr_count != 16'd0)
                 && (r_hdr_count <= {7'd0, r_max_samples})
                 && (32'(r_hdr_count) <= 32'(MAX_FRAME_SAMPLES));

    assign is_header = (r_byte_pos < POS_W'(HEADER_BYTES));
    assign pay_off   = r_byte_pos - POS_W'(HEADER_BYTES);
    assign total     = (r_byte_pos == '1) ? r_byte_pos : r_byte_pos + POS_W'(1);

    // Per-byte frame update.
    always_comb begin
        n_hdr_version  = r_hdr_version;
        n_hdr_rate     = r_hdr_rate;
        n_hdr_channels = r_hdr_channels;
        n_hdr_bits     = r_hdr_bits;
        n_hdr_count    = r_hdr_count;
        n_hdr_seq      = r_hdr_seq;
        n_hdr_ts       = r_hdr_ts;
        n_low_byte     = r_low_byte;
        n_hdr_valid    = r_hdr_valid;
        has_sample     = 1'b0;
        if (is_header) begin
            unique case (r_byte_pos[3:1])
                3'd0: n_hdr_version  = put_byte16(r_hdr_version, r_byte_pos[0],
                                                  i_data.data_byte);
                3'd1: n_hdr_rate     = put_byte16(r_hdr_rate, r_byte_pos[0],
                                                  i_data.data_byte);
                3'd2: n_hdr_channels = put_byte16(r_hdr_channels, r_byte_pos[0],
                                                  i_data.data_byte);
                3'd3: n_hdr_bits     = put_byte16(r_hdr_bits, r_byte_pos[0],
                                                  i_data.data_byte);
                3'd4: n_hdr_count    = put_byte16(r_hdr_count, r_byte_pos[0],
                                                  i_data.data_byte);
                3'd5: n_hdr_seq      = put_byte16(r_hdr_seq, r_byte_pos[0],
                                                  i_data.data_byte);
                default: begin
                    unique case (r_byte_pos[1:0])
                        2'd0:    n_hdr_ts[7:0]   = i_data.data_byte;
                        2'd1:    n_hdr_ts[15:8]  = i_data.data_byte;
                        2'd2:    n_hdr_ts[23:16] = i_data.data_byte;
                        default: n_hdr_ts[31:24] = i_data.data_byte;
                    endcase
                end
            endcase
            if (r_byte_pos == POS_W'(HEADER_BYTES - 1)) begin
                n_hdr_valid = hdr_ok;
            end
        end else if (r_hdr_valid) begin
            if (!pay_off[0]) begin
                n_low_byte = i_data.data_byte;
            end else if ({7'd0, pay_off[POS_W-1:1]} < r_hdr_count) begin
                has_sample = 1'b1;
            end
        end
    end

    // Sample result.
    always_comb begin
        sample_res        = '0;
        sample_res.kind   = 1'b0;
        sample_res.sample = {i_data.data_byte, r_low_byte};
        sample_res.status = ST_OK;
    end

    // End-of-frame status result, built from the updated header.
    always_comb begin
        status_res              = '0;
        status_res.kind         = 1'b1;
        status_res.end_of_frame = 1'b1;
        if (total < POS_W'(HEADER_BYTES)) begin
            status_res.status = ST_SHORT;
        end else begin
            if (!n_hdr_valid) begin
                status_res.status = ST_BAD_HDR;
            end else if (18'(total) != 18'(HEADER_BYTES) + {1'b0, n_hdr_count, 1'b0}) begin
                status_res.status = ST_LEN;
            end else begin
                status_res.status = ST_OK;
            end
            status_res.frame_version   = n_hdr_version;
            status_res.rate_hz         = n_hdr_rate;
            status_res.channel_count   = n_hdr_channels;
            status_res.sample_bits     = n_hdr_bits;
            status_res.sample_total    = n_hdr_count;
            status_res.sequence_number = n_hdr_seq;
            status_res.stamp_ms        = n_hdr_ts;
        end
    end

    // Results to push: the sample comes first, then the status.
    assign has_status = i_data.last_byte;
    assign res_a      = has_sample ? sample_res : status_res;
    assign push_cnt   = in_xfer ? (2'(has_sample) + 2'(has_status)) : 2'd0;

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(push_cnt);
        n_rd_ptr = out_xfer ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + (FIFO_AW + 1)'(push_cnt) - (FIFO_AW + 1)'(out_xfer);
    end

    // Frame position: saturating count, cleared after the last byte.
    always_comb begin
        n_byte_pos = r_byte_pos;
        if (in_xfer) begin
            n_byte_pos = i_data.last_byte ? '0 : total;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= '0;
            r_hdr_valid    <= 1'b0;
            r_hdr_version  <= '0;
            r_hdr_rate     <= '0;
            r_hdr_channels <= '0;
            r_hdr_bits     <= '0;
            r_hdr_count    <= '0;
            r_hdr_seq      <= '0;
            r_hdr_ts       <= '0;
            r_low_byte     <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_count    <= n_count;
            if (in_xfer) begin
                if (i_data.last_byte) begin
                    r_hdr_valid    <= 1'b0;
                    r_hdr_version  <= '0;
                    r_hdr_rate     <= '0;
                    r_hdr_channels <= '0;
                    r_hdr_bits     <= '0;
                    r_hdr_count    <= '0;
                    r_hdr_seq      <= '0;
                    r_hdr_ts       <= '0;
                    r_low_byte     <= '0;
                end else begin
                    r_hdr_valid    <= n_hdr_valid;
                    r_hdr_version  <= n_hdr_version;
                    r_hdr_rate     <= n_hdr_rate;
                    r_hdr_channels <= n_hdr_channels;
                    r_hdr_bits     <= n_hdr_bits;
                    r_hdr_count    <= n_hdr_count;
                    r_hdr_seq      <= n_hdr_seq;
                    r_hdr_ts       <= n_hdr_ts;
                    r_low_byte     <= n_low_byte;
                end
            end
        end
    end

    // Queue storage: up to two writes per cycle at consecutive entries.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res_a;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= status_res;
        end
    end

    // The queue never holds more entries than it has.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A last byte always closes the frame.
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_data.last_byte |=> (r_byte_pos == '0) && !r_hdr_valid)
        else $error("frame state not cleared after last byte");

    // A valid header only exists once the whole header has been received.
    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_valid |-> (r_byte_pos >= POS_W'(HEADER_BYTES)))
        else $error("header valid inside the header");

    // Only status results mark the end of a frame.
    a_eof_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.end_of_frame == o_data.kind))
        else $error("end-of-frame flag on a sample result");

    // A sample result is only produced while a valid header is held.
    a_sample_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && has_sample |-> r_hdr_valid)
        else $error("sample produced without a valid header");

endmodule

[bench/tb.sv]
// Self-checking bench for audio_frame_deframer: drives byte streams of audio frames and
// compares every sample and end-of-frame status against a predictor kept in a scoreboard.
// It depends on afd_pkg and the audio_frame_deframer RTL.
`timescale 1ns / 1ps

module tb;
    import afd_pkg::*;

    localparam int LONG_HOLD  = 200;
    localparam int POS_LIMIT  = (1 << POS_W) - 1;
    localparam int PHASES     = 7;
    localparam int PHASE_BYTES = 110;

    // Frame shapes that the random stimulus draws from.
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_HDR,
        SHAPE_UNDERRUN,
        SHAPE_OVERRUN,
        SHAPE_TRUNCATED
    } t_shape;

    // Scoreboard: predicts the results of each byte transfer and checks the result stream.
    class frame_scoreboard;
        logic [15:0]  want_version;
        logic [15:0]  want_channels;
        logic [15:0]  want_bits;
        logic [8:0]   sample_cap;
        logic [9:0]   byte_count;
        logic [127:0] header;
        logic [7:0]   low_half;
        bit           header_ok;
        t_out         expected_q[$];
        int           failures;
        int           samples_checked;
        int           bytes_noted;
        int           status_seen[4];

        function new();
            want_version    = 16'd1;
            want_channels   = 16'd1;
            want_bits       = 16'd16;
            sample_cap      = 9'd160;
            failures        = 0;
            samples_checked = 0;
            bytes_noted     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_count = '0;
            header     = '0;
            low_half   = '0;
            header_ok  = 1'b0;
        endfunction

        // A register write keeps only the bits that the register holds.
        function void set_reg(t_reg_idx idx, logic [31:0] word);
            case (idx)
                REG_VERSION:  want_version  = word[15:0];
                REG_CHANNELS: want_channels = word[15:0];
                REG_BITS:     want_bits     = word[15:0];
                REG_MAX_SMP:  sample_cap    = word[8:0];
                default: ;
            endcase
        endfunction

        // Works out the results that one accepted byte causes.
        function void note_byte(t_in b);
            t_out        r;
            int          pos;
            int          total;
            int          limit;
            logic [15:0] count;
            bytes_noted++;
            pos   = byte_count;
            count = header[79:64];
            if (pos < HEADER_BYTES) begin
                header[8*pos +: 8] = b.data_byte;
                if (pos == HEADER_BYTES - 1) begin
                    limit = (sample_cap > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES : sample_cap;
                    header_ok = header[15:0] == want_version &&
                                header[47:32] == want_channels &&
                                header[63:48] == want_bits &&
                                header[79:64] >= 1 && header[79:64] <= limit;
                end
            end else if (header_ok) begin
                // Low byte first; bytes past the sample count give nothing.
                if (((pos - HEADER_BYTES) % 2) == 0) begin
                    low_half = b.data_byte;
                end else if ((pos - HEADER_BYTES) / 2 < count) begin
                    r = '0;
                    r.sample = {b.data_byte, low_half};
                    expected_q.push_back(r);
                end
            end
            total = (pos < POS_LIMIT) ? pos + 1 : POS_LIMIT;
            byte_count = total[9:0];

            // The last byte closes the frame with a status result.
            if (b.last_byte) begin
                r = '0;
                r.kind = 1'b1;
                r.end_of_frame = 1'b1;
                if (total < HEADER_BYTES) begin
                    r.status = ST_SHORT;
                end else begin
                    if (!header_ok)
                        r.status = ST_BAD_HDR;
                    else if (total != HEADER_BYTES + 2 * int'(header[79:64]))
                        r.status = ST_LEN;
                    else
                        r.status = ST_OK;
                    r.frame_version   = header[15:0];
                    r.rate_hz         = header[31:16];
                    r.channel_count   = header[47:32];
                    r.sample_bits     = header[63:48];
                    r.sample_total    = header[79:64];
                    r.sequence_number = header[95:80];
                    r.stamp_ms        = header[127:96];
                end
                expected_q.push_back(r);
                clear_frame();
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                failures++;
            end
        endfunction

        // Checks one accepted result against the oldest prediction.
        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                         $time, got.kind, got.status);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("sample", want.sample, got.sample);
            compare_field("status", want.status, got.status);
            compare_field("frame_version", want.frame_version, got.frame_version);
            compare_field("rate_hz", want.rate_hz, got.rate_hz);
            compare_field("channel_count", want.channel_count, got.channel_count);
            compare_field("sample_bits", want.sample_bits, got.sample_bits);
            compare_field("sample_total", want.sample_total, got.sample_total);
            compare_field("sequence_number", want.sequence_number, got.sequence_number);
            compare_field("stamp_ms", want.stamp_ms, got.stamp_ms);
            compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
            if (want.kind)
                status_seen[int'(want.status)]++;
            else
                samples_checked++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();
    logic [7:0]      frame_bytes[$];
    int              reg_value[4];
    bit              send_quiet = 1'b0;
    bit              hold_request = 1'b0;

    audio_frame_deframer dut (.*);

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: both channels are sampled at the rising edge, input before result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_byte(i_data);
            if (o_valid && !i_stall) sb.check_result(o_data);
        end
    end

    // Result sink: random stalls per transfer, quiet stretches, and one long hold-off.
    initial begin : result_sink
        int gap;
        int served;
        bit quiet;
        i_stall = 1'b0;
        served  = 0;
        quiet   = 1'b0;
        forever begin
            if (served % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 10);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
            @(negedge i_clk);
            served++;
        end
    end

    // Run limit.
    initial begin : watchdog
        #(5_000_000);
        $display("Timeout with %0d results still expected", sb.expected_q.size());
        $display("tb NOT OK");
        $finish;
    end

    // One byte transfer; entered and left at a falling edge.
    task automatic send_byte(input t_in b);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data  <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Sends the bytes in frame_bytes, flagging the final one.
    task automatic send_frame();
        t_in b;
        send_quiet = ($urandom_range(0, 3) == 0);
        foreach (frame_bytes[i]) begin
            b.data_byte = frame_bytes[i];
            b.last_byte = (i == frame_bytes.size() - 1);
            send_byte(b);
        end
    endtask

    task automatic push_header(input logic [15:0] ver, input logic [15:0] rate,
                               input logic [15:0] chans, input logic [15:0] bits,
                               input logic [15:0] count, input logic [15:0] seq,
                               input logic [31:0] stamp);
        logic [127:0] hdr;
        hdr = {stamp, seq, count, bits, chans, rate, ver};
        for (int i = 0; i < HEADER_BYTES; i++) frame_bytes.push_back(hdr[8*i +: 8]);
    endtask

    task automatic push_payload(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    // Builds one frame of the given shape against the current register settings.
    task automatic build_frame(input t_shape shape);
        logic [15:0] ver;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] count;
        int          limit;
        int          span;
        int          payload;
        frame_bytes.delete();
        ver   = 16'(reg_value[REG_VERSION]);
        chans = 16'(reg_value[REG_CHANNELS]);
        bits  = 16'(reg_value[REG_BITS]);
        limit = (reg_value[REG_MAX_SMP] > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES
                                                             : reg_value[REG_MAX_SMP];
        // Mostly small counts, now and then any count up to the largest one allowed.
        span    = ($urandom_range(0, 39) == 0) ? limit : ((limit < 6) ? limit : 6);
        count   = 16'($urandom_range(1, span));
        payload = 2 * count;
        case (shape)
            SHAPE_BAD_HDR: begin
                case ($urandom_range(0, 4))
                    0: ver   = ver ^ 16'($urandom_range(1, 65535));
                    1: chans = chans ^ 16'($urandom_range(1, 65535));
                    2: bits  = bits ^ 16'($urandom_range(1, 65535));
                    3: count = '0;
                    default: count = 16'($urandom_range(limit + 1, 65535));
                endcase
                payload = $urandom_range(0, 12);
            end
            SHAPE_UNDERRUN: payload = $urandom_range(0, 2 * count - 1);
            SHAPE_OVERRUN:  payload = 2 * count + $urandom_range(1, 7);
            default: ;
        endcase
        if (shape == SHAPE_TRUNCATED) begin
            push_payload($urandom_range(1, HEADER_BYTES - 1));
        end else begin
            push_header(ver, 16'($urandom), chans, bits, count, 16'($urandom), $urandom);
            push_payload(payload);
        end
    endtask

    // Random frames until about n bytes have gone in.
    task automatic run_random(input int n);
        int sent;
        int pick;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      build_frame(SHAPE_GOOD);
            else if (pick < 67) build_frame(SHAPE_BAD_HDR);
            else if (pick < 77) build_frame(SHAPE_UNDERRUN);
            else if (pick < 87) build_frame(SHAPE_OVERRUN);
            else                build_frame(SHAPE_TRUNCATED);
            send_frame();
            sent += frame_bytes.size();
        end
    endtask

    // Waits until every predicted result has come, then lets the block go quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    // Register write followed by a read-back; random bits above the low 16 bits.
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        logic [31:0] word;
        logic [31:0] mask;
        logic [31:0] rd;
        word = $urandom;
        mask = (idx == REG_MAX_SMP) ? 32'h1FF : 32'hFFFF;
        word[15:0] = value;
        reg_value[idx] = word & mask;
        sb.set_reg(idx, word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((rd & mask) !== (word & mask)) begin
            $display("%0t: register %0d read-back mismatch, expected %h, actual %h",
                     $time, idx, word & mask, rd & mask);
            sb.failures++;
        end
    endtask

    task automatic program_regs(input logic [15:0] ver, input logic [15:0] chans,
                                input logic [15:0] bits, input logic [15:0] max_smp);
        write_reg(REG_VERSION, ver);
        write_reg(REG_CHANNELS, chans);
        write_reg(REG_BITS, bits);
        write_reg(REG_MAX_SMP, max_smp);
    endtask

    // Main sequence: reset, directed frames, then random phases under varied registers.
    initial begin : stimulus
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        reg_value[REG_VERSION]  = 1;
        reg_value[REG_CHANNELS] = 1;
        reg_value[REG_BITS]     = 16;
        reg_value[REG_MAX_SMP]  = 160;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A one-byte frame, then a valid frame with both sample extremes, the last on the
        // final byte.
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes.delete();
        push_header(16'd1, 16'hFFFF, 16'd1, 16'd16, 16'd2, 16'hFFFF, 32'hFFFF_FFFF);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'h80);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h7F);
        send_frame();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: program_regs(16'd0, 16'hFFFF, 16'd0, 16'd1);
                2: program_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'd256);
                default: program_regs(16'($urandom), 16'($urandom_range(1, 8)),
                                      ($urandom_range(0, 1) != 0) ? 16'd16 : 16'($urandom),
                                      16'($urandom_range(1, 256)));
            endcase
            if (phase == 2) hold_request = 1'b1;
            run_random(PHASE_BYTES);
            settle();
        end

        $display("Covered %0d bytes in %0d frames and %0d samples", sb.bytes_noted,
                 sb.status_seen[0] + sb.status_seen[1] + sb.status_seen[2] + sb.status_seen[3],
                 sb.samples_checked);
        $display("Status ok %0d, short %0d, bad header %0d, length mismatch %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        if (sb.expected_q.size() != 0) begin
            $display("%0d expected results never arrived", sb.expected_q.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
rtl/afd_pkg.sv
rtl/audio_frame_deframer.sv
bench/tb.sv
